/* src/vc1sc_pkg.sv */
// ============================================================================
// vc1sc_pkg
// Shared types, constants and the picture-type decoder of the VC-1 start-code
// header parser.
// ============================================================================
package vc1sc_pkg;

    localparam int SEQ_FIELD_BITS  = 44;
    localparam int SIZE_FIELD_BITS = 12;
    // Sequence bits left over once whole bytes are taken.
    localparam int SEQ_TAIL_BITS   = SEQ_FIELD_BITS % 8;
    localparam int SEQ_CNT_W       = $clog2(SEQ_FIELD_BITS + 1);

    localparam logic [7:0] SC_SEQUENCE = 8'h0F;
    localparam logic [7:0] SC_PICTURE  = 8'h0D;
    localparam logic [23:0] SC_PREFIX  = 24'h000001;

    localparam logic [1:0] TYPE_I       = 2'd0;
    localparam logic [1:0] TYPE_P       = 2'd1;
    localparam logic [1:0] TYPE_B       = 2'd2;
    localparam logic [1:0] TYPE_UNKNOWN = 2'd3;

    localparam logic [1:0] KIND_FRAME    = 2'd0;
    localparam logic [1:0] KIND_SEQUENCE = 2'd1;
    localparam logic [1:0] KIND_BOTH     = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  header_kind;
        logic [1:0]  frame_type;
        logic        interlaced;
        logic [1:0]  profile;
        logic [2:0]  level;
        logic [13:0] width;
        logic [13:0] height;
        logic        interlaced_source;
        logic [2:0]  frame_rate_code;
        logic [4:0]  bit_rate_code;
        logic [1:0]  chroma_format;
        logic        postproc_present;
    } out_beat_t;

    // Picture header byte -> {interlaced, frame_type}.
    // FCM is present only when the sequence interlace flag is set.
    function automatic logic [2:0] decode_picture(input logic [7:0] b, input logic ilace);
        logic       inter;
        logic [7:0] v;
        logic [1:0] ptype;
        inter = 1'b0;
        v     = b;
        if (ilace)
        begin
            if (b[7])
            begin
                inter = 1'b1;
                v     = b << 2;
            end
            else
            begin
                v = b << 1;
            end
        end
        priority if (!v[7]) ptype = TYPE_P;
        else if (!v[6])     ptype = TYPE_B;
        else if (!v[5])     ptype = TYPE_I;
        else if (!v[4])     ptype = TYPE_B;   // BI
        else                ptype = TYPE_P;   // skipped
        return {inter, ptype};
    endfunction

endpackage

/* src/vc1_start_code_header_parser.sv */
// ============================================================================
// vc1_start_code_header_parser
// Scans a buffer byte by byte for VC-1 sequence and frame start codes and
// reports one header summary beat per buffer.
// ============================================================================
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-----------------------------------
//  byte    | in  | byte_valid / byte_stall | in_beat_t: data_byte, last_byte
//  hdr     | out | hdr_valid / hdr_stall   | out_beat_t: header summary fields
//
//  One byte per cycle sustained while byte_stall is low. A byte is held in the
//  input register, then the scan logic updates the parser state and, on the
//  last byte of a buffer, writes the summary into the output register, or into
//  the skid entry while hdr_stall holds the output register; hdr_valid is the
//  registered valid flag of the output register.
//  Reset clears all per-buffer state; the sequence fields read all ones until a
//  sequence header is parsed, the frame type unknown until a picture is decoded.
//  hdr_stall is absorbed by a one-entry skid; byte_stall rises only when the
//  skid is full and a byte waits in the input register.
//
module vc1_start_code_header_parser
    import vc1sc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_beat_t  byte_data,
    output logic      hdr_valid,
    input  logic      hdr_stall,
    output out_beat_t hdr_data
);

    logic      in_valid_reg, in_valid_next;
    in_beat_t  in_beat_reg;
    logic      skid_full;
    logic      fire;
    logic      accept;
    logic      push;
    out_beat_t result;

    // The registered byte is processed whenever a result slot is free.
    assign fire       = in_valid_reg & ~skid_full;
    assign byte_stall = in_valid_reg & skid_full;
    assign accept     = byte_valid & ~byte_stall;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_beat_reg <= byte_data;
    end

    // Start-code scan, sequence collection and picture decode.
    vc1sc_parse_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .beat   (in_beat_reg),
        .push   (push),
        .result (result)
    );

    // Summary beat register plus skid entry.
    vc1sc_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .skid_full (skid_full),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr_data  (hdr_data)
    );

endmodule

/* src/vc1sc_parse_core.sv */
// ============================================================================
// vc1sc_parse_core
// Per-byte start-code scan, sequence bit collection and picture decode.
// ============================================================================
module vc1sc_parse_core
    import vc1sc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_beat_t  beat,
    output logic      push,
    output out_beat_t result
);

    logic [23:0]                 recent_reg,     recent_next;
    logic [SEQ_FIELD_BITS-1:0]   seq_shift_reg,  seq_shift_next;
    logic [SEQ_CNT_W-1:0]        seq_cnt_reg,    seq_cnt_next;
    logic                        collecting_reg, collecting_next;
    logic [SEQ_FIELD_BITS-1:0]   seq_fields_reg, seq_fields_next;
    logic                        pending_reg,    pending_next;
    logic [7:0]                  first_reg,      first_next;
    logic [2:0]                  pos_reg,        pos_next;
    logic [1:0]                  found_reg,      found_next;
    logic [2:0]                  pic_reg,        pic_next;
    logic                        held_valid_reg, held_valid_next;
    logic [7:0]                  held_byte_reg,  held_byte_next;

    always_comb
    begin
        logic [7:0] b;
        b = beat.data_byte;

        recent_next     = recent_reg;
        seq_shift_next  = seq_shift_reg;
        seq_cnt_next    = seq_cnt_reg;
        collecting_next = collecting_reg;
        seq_fields_next = seq_fields_reg;
        pending_next    = pending_reg;
        first_next      = first_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        pic_next        = pic_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;

        if (pos_reg == 3'd0)
            first_next = b;

        // sequence bits, MSB first; the final step takes only the tail bits
        if (collecting_next)
        begin
            if (seq_cnt_next == SEQ_CNT_W'(SEQ_FIELD_BITS - SEQ_TAIL_BITS))
            begin
                seq_shift_next = {seq_shift_next[SEQ_FIELD_BITS-SEQ_TAIL_BITS-1:0],
                                  b[7 -: SEQ_TAIL_BITS]};
                seq_cnt_next   = SEQ_CNT_W'(SEQ_FIELD_BITS);
            end
            else
            begin
                seq_shift_next = {seq_shift_next[SEQ_FIELD_BITS-9:0], b};
                seq_cnt_next   = seq_cnt_next + SEQ_CNT_W'(8);
            end
            if (seq_cnt_next >= SEQ_CNT_W'(SEQ_FIELD_BITS))
            begin
                seq_fields_next = seq_shift_next;
                collecting_next = 1'b0;
                seq_shift_next  = '0;
                seq_cnt_next    = '0;
                if (held_valid_next)
                begin
                    pic_next        = decode_picture(held_byte_next, seq_fields_next[2]);
                    held_valid_next = 1'b0;
                    held_byte_next  = '0;
                end
            end
        end

        // frame header byte; held while a sequence header is still open
        if (pending_next)
        begin
            pending_next = 1'b0;
            if (collecting_next)
            begin
                held_valid_next = 1'b1;
                held_byte_next  = b;
            end
            else
            begin
                pic_next = decode_picture(b, seq_fields_next[2]);
            end
        end

        if (pos_reg >= 3'd3 && recent_reg == SC_PREFIX)
        begin
            if (b == SC_PICTURE)
            begin
                found_next[0] = 1'b1;
                pending_next  = 1'b1;
            end
            else if (b == SC_SEQUENCE)
            begin
                found_next[1] = 1'b1;
                if (held_valid_next)
                begin
                    pic_next        = decode_picture(held_byte_next, seq_fields_next[2]);
                    held_valid_next = 1'b0;
                end
                collecting_next = 1'b1;
                seq_shift_next  = '0;
                seq_cnt_next    = '0;
            end
        end

        recent_next = {recent_reg[15:0], b};
        if (pos_reg != 3'd7)
            pos_next = pos_reg + 3'd1;

        if (beat.last_byte)
        begin
            // bits past the buffer end read as zero
            if (collecting_next)
            begin
                seq_fields_next = seq_shift_next << (SEQ_CNT_W'(SEQ_FIELD_BITS) - seq_cnt_next);
                if (held_valid_next)
                    pic_next = decode_picture(held_byte_next, seq_fields_next[2]);
            end
            if (found_next == 2'b00)
                pic_next = decode_picture(first_next, seq_fields_next[2]);
        end

        result.header_kind       = found_next[1] ? (found_next[0] ? KIND_BOTH : KIND_SEQUENCE)
                                                 : KIND_FRAME;
        result.frame_type        = pic_next[1:0];
        result.interlaced        = pic_next[2];
        result.profile           = seq_fields_next[43:42];
        result.level             = seq_fields_next[41:39];
        result.chroma_format     = seq_fields_next[38:37];
        result.frame_rate_code   = seq_fields_next[36:34];
        result.bit_rate_code     = seq_fields_next[33:29];
        result.postproc_present  = seq_fields_next[28];
        result.width             = {1'b0, seq_fields_next[27 -: SIZE_FIELD_BITS], 1'b0} + 14'd2;
        result.height            = {1'b0, seq_fields_next[15 -: SIZE_FIELD_BITS], 1'b0} + 14'd2;
        result.interlaced_source = seq_fields_next[2];

        // end of buffer: per-buffer state back to reset
        if (beat.last_byte)
        begin
            recent_next     = '0;
            seq_shift_next  = '0;
            seq_cnt_next    = '0;
            collecting_next = 1'b0;
            pending_next    = 1'b0;
            first_next      = '0;
            pos_next        = '0;
            found_next      = '0;
            held_valid_next = 1'b0;
            held_byte_next  = '0;
        end
    end

    assign push = fire & beat.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg     <= '0;
            seq_shift_reg  <= '0;
            seq_cnt_reg    <= '0;
            collecting_reg <= 1'b0;
            seq_fields_reg <= '1;
            pending_reg    <= 1'b0;
            first_reg      <= '0;
            pos_reg        <= '0;
            found_reg      <= '0;
            pic_reg        <= {1'b0, TYPE_UNKNOWN};
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
        end
        else if (fire)
        begin
            recent_reg     <= recent_next;
            seq_shift_reg  <= seq_shift_next;
            seq_cnt_reg    <= seq_cnt_next;
            collecting_reg <= collecting_next;
            seq_fields_reg <= seq_fields_next;
            pending_reg    <= pending_next;
            first_reg      <= first_next;
            pos_reg        <= pos_next;
            found_reg      <= found_next;
            pic_reg        <= pic_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
        end
    end

endmodule

/* src/vc1sc_out_skid.sv */
// ============================================================================
// vc1sc_out_skid
// Result register with one skid entry; full flag is registered.
// ============================================================================
module vc1sc_out_skid
    import vc1sc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_beat_t push_data,
    output logic      skid_full,
    output logic      hdr_valid,
    input  logic      hdr_stall,
    output out_beat_t hdr_data
);

    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg,  out_data_next;
    logic      skid_valid_reg, skid_valid_next;
    out_beat_t skid_data_reg,  skid_data_next;
    logic      pop;

    assign pop = out_valid_reg & ~hdr_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // no push can arrive while the skid entry is occupied
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign skid_full = skid_valid_reg;
    assign hdr_valid = out_valid_reg;
    assign hdr_data  = out_data_reg;

endmodule
